// ----- design/fcs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcs_pkg
// Shared types and constants of the frame content signature block.
// ----------------------------------------------------------------------------
package fcs_pkg;

    // field widths
    localparam int BYTE_W      = 8;
    localparam int PIXEL_BYTES = 4;
    localparam int PIXEL_W     = BYTE_W * PIXEL_BYTES;
    localparam int BYTE_CNT_W  = $clog2(PIXEL_BYTES);
    localparam int HASH_W      = 64;
    localparam int CHANGED_W   = 25;
    localparam int DISTINCT_W  = 9;
    localparam int VALUE_COUNT = 256;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W  = PIXEL_W;
    localparam int RESULT_W   = HASH_W + CHANGED_W + DISTINCT_W;
    localparam int M_TDATA_W  = ((RESULT_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - RESULT_W;

    // fnv-1a 64 constants; prime = 2^40 + 2^8 + 0xb3
    localparam logic [HASH_W-1:0] HASH_BASIS     = 64'hCBF2_9CE4_8422_2325;
    localparam logic [BYTE_W-1:0] PRIME_LOW      = 8'hB3;
    localparam int                PRIME_SHIFT_HI = 40;
    localparam int                PRIME_SHIFT_MD = 8;

    // changed count saturation: lesser of frame limit and field maximum
    localparam longint MAX_FRAME_PIXELS = 64'd16777216;
    localparam longint COUNT_FIELD_MAX  = (64'd1 << CHANGED_W) - 64'd1;
    localparam longint COUNT_LIMIT_FULL =
        (MAX_FRAME_PIXELS < COUNT_FIELD_MAX) ? MAX_FRAME_PIXELS : COUNT_FIELD_MAX;
    localparam logic [CHANGED_W-1:0] CHANGED_LIMIT = COUNT_LIMIT_FULL[CHANGED_W-1:0];

    // control from the sequencer to the datapath units
    typedef struct packed {
        logic byte_en;      // one pixel byte presented this cycle
        logic pixel_en;     // a whole pixel accepted this cycle
        logic frame_clear;  // return all frame state to its start values
    } fcs_ctl_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_EMIT = 3'b100
    } fcs_state_t;

endpackage

// ----- design/fcs_hash_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcs_hash_unit
// Byte-serial FNV-1a 64 hash: one xor and one shift-add multiply per cycle in which byte_en is set.
// ----------------------------------------------------------------------------
module fcs_hash_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  fcs_pkg::fcs_ctl_t             ctl,
    input  logic [fcs_pkg::BYTE_W-1:0]    data_byte,
    output logic [fcs_pkg::HASH_W-1:0]    hash_value
);

    logic [fcs_pkg::HASH_W-1:0] hash_reg;
    logic [fcs_pkg::HASH_W-1:0] hash_next;
    logic [fcs_pkg::HASH_W-1:0] mixed;
    logic [fcs_pkg::HASH_W-1:0] low_prod;

    // xor the byte in, then multiply by the prime as two shifted terms plus a low-byte product
    always_comb begin
        mixed    = hash_reg ^ fcs_pkg::HASH_W'(data_byte);
        low_prod = mixed * fcs_pkg::HASH_W'(fcs_pkg::PRIME_LOW);
        if (ctl.frame_clear) begin
            hash_next = fcs_pkg::HASH_BASIS;
        end else if (ctl.byte_en) begin
            hash_next = (mixed << fcs_pkg::PRIME_SHIFT_HI)
                      + (mixed << fcs_pkg::PRIME_SHIFT_MD)
                      + low_prod;
        end else begin
            hash_next = hash_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= fcs_pkg::HASH_BASIS;
        end else begin
            hash_reg <= hash_next;
        end
    end

    assign hash_value = hash_reg;

endmodule

// ----- design/fcs_stats.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcs_stats
// Frame statistics: background pixel, changed-pixel count and byte-value map
// with a running count of distinct values.
// ----------------------------------------------------------------------------
module fcs_stats (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  fcs_pkg::fcs_ctl_t                ctl,
    input  logic [fcs_pkg::BYTE_W-1:0]       data_byte,
    input  logic [fcs_pkg::PIXEL_W-1:0]      pixel,
    output logic [fcs_pkg::CHANGED_W-1:0]    changed_count,
    output logic [fcs_pkg::DISTINCT_W-1:0]   distinct_values
);

    logic [fcs_pkg::VALUE_COUNT-1:0] seen_reg;
    logic [fcs_pkg::VALUE_COUNT-1:0] seen_next;
    logic [fcs_pkg::DISTINCT_W-1:0]  distinct_reg;
    logic [fcs_pkg::DISTINCT_W-1:0]  distinct_next;
    logic [fcs_pkg::PIXEL_W-1:0]     background_reg;
    logic [fcs_pkg::PIXEL_W-1:0]     background_next;
    logic                            awaiting_reg;
    logic                            awaiting_next;
    logic [fcs_pkg::CHANGED_W-1:0]   changed_reg;
    logic [fcs_pkg::CHANGED_W-1:0]   changed_next;

    // byte map: a value seen for the first time bumps the distinct count
    always_comb begin
        seen_next     = seen_reg;
        distinct_next = distinct_reg;
        if (ctl.frame_clear) begin
            seen_next     = '0;
            distinct_next = '0;
        end else if (ctl.byte_en && !seen_reg[data_byte]) begin
            seen_next[data_byte] = 1'b1;
            distinct_next        = distinct_reg + fcs_pkg::DISTINCT_W'(1);
        end
    end

    // first pixel becomes the background, later ones are compared to it
    always_comb begin
        background_next = background_reg;
        awaiting_next   = awaiting_reg;
        changed_next    = changed_reg;
        if (ctl.frame_clear) begin
            background_next = '0;
            awaiting_next   = 1'b1;
            changed_next    = '0;
        end else if (ctl.pixel_en) begin
            if (awaiting_reg) begin
                background_next = pixel;
                awaiting_next   = 1'b0;
            end else if (pixel != background_reg
                         && changed_reg < fcs_pkg::CHANGED_LIMIT) begin
                changed_next = changed_reg + fcs_pkg::CHANGED_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg       <= '0;
            distinct_reg   <= '0;
            background_reg <= '0;
            awaiting_reg   <= 1'b1;
            changed_reg    <= '0;
        end else begin
            seen_reg       <= seen_next;
            distinct_reg   <= distinct_next;
            background_reg <= background_next;
            awaiting_reg   <= awaiting_next;
            changed_reg    <= changed_next;
        end
    end

    assign changed_count   = changed_reg;
    assign distinct_values = distinct_reg;

endmodule

// ----- design/frame_content_signature.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_content_signature
// Content signature of an RGBA frame: FNV-1a 64 hash, changed-pixel count
// and number of distinct byte values, emitted on the frame's last pixel.
// ----------------------------------------------------------------------------
// Each pixel's bytes leave a shift register one per cycle, red first, and
// each passes through the single byte-wide hash step, whose xor and
// multiply depend on the previous byte. A new pixel is taken in the cycle
// its predecessor's last byte is hashed, so a steady stream has no gaps
// between pixels. After a pixel flagged last, the result stage moves the
// result into the output register (waiting while that register is still
// held by m_tready low) and clears the frame state; the idle state then
// takes the next pixel. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module frame_content_signature (
    input  logic                             aclk,
    input  logic                             aresetn,
    // pixel stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // red_byte [7:0], green_byte [15:8], blue_byte [23:16], alpha_byte [31:24]
    input  logic [fcs_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                             s_tlast,   // last_pixel
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // frame_hash [63:0], changed_count [88:64], distinct_values [97:89],
    // zero pad [103:98]
    output logic [fcs_pkg::M_TDATA_W-1:0]    m_tdata
);

    fcs_pkg::fcs_state_t                state_reg;
    fcs_pkg::fcs_state_t                state_next;
    logic [fcs_pkg::BYTE_CNT_W-1:0]     cnt_reg;
    logic [fcs_pkg::BYTE_CNT_W-1:0]     cnt_next;
    logic [fcs_pkg::PIXEL_W-1:0]        shift_reg;
    logic [fcs_pkg::PIXEL_W-1:0]        shift_next;
    logic                               last_reg;
    logic                               last_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [fcs_pkg::M_TDATA_W-1:0]      out_data_reg;
    logic [fcs_pkg::M_TDATA_W-1:0]      out_data_next;

    fcs_pkg::fcs_ctl_t                  ctl;
    logic                               s_accept;
    logic                               last_byte;
    logic                               out_free;
    logic [fcs_pkg::HASH_W-1:0]         hash_value;
    logic [fcs_pkg::CHANGED_W-1:0]      changed_count;
    logic [fcs_pkg::DISTINCT_W-1:0]     distinct_values;

    // handshake: idle, or the final byte of a pixel that does not end a frame
    assign last_byte = (state_reg == fcs_pkg::S_RUN)
                     && (cnt_reg == fcs_pkg::BYTE_CNT_W'(fcs_pkg::PIXEL_BYTES - 1));
    assign s_tready  = (state_reg == fcs_pkg::S_IDLE) || (last_byte && !last_reg);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    // sequencer
    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        shift_next      = shift_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        ctl.byte_en     = 1'b0;
        ctl.pixel_en    = s_accept;
        ctl.frame_clear = 1'b0;

        if (m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            fcs_pkg::S_IDLE: begin
                if (s_accept) begin
                    state_next = fcs_pkg::S_RUN;
                end
            end
            fcs_pkg::S_RUN: begin
                ctl.byte_en = 1'b1;
                shift_next  = shift_reg >> fcs_pkg::BYTE_W;
                cnt_next    = cnt_reg + fcs_pkg::BYTE_CNT_W'(1);
                if (last_byte && !s_accept) begin
                    state_next = last_reg ? fcs_pkg::S_EMIT : fcs_pkg::S_IDLE;
                end
            end
            fcs_pkg::S_EMIT: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_data_next   = {{fcs_pkg::M_PAD_W{1'b0}}, distinct_values,
                                       changed_count, hash_value};
                    ctl.frame_clear = 1'b1;
                    state_next      = fcs_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = fcs_pkg::S_IDLE;
            end
        endcase

        // load a new pixel into the byte shift register
        if (s_accept) begin
            shift_next = s_tdata;
            last_next  = s_tlast;
            cnt_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= fcs_pkg::S_IDLE;
            cnt_reg       <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        shift_reg    <= shift_next;
        out_data_reg <= out_data_next;
    end

    fcs_hash_unit u_hash (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .data_byte  (shift_reg[fcs_pkg::BYTE_W-1:0]),
        .hash_value (hash_value)
    );

    fcs_stats u_stats (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctl             (ctl),
        .data_byte       (shift_reg[fcs_pkg::BYTE_W-1:0]),
        .pixel           (s_tdata),
        .changed_count   (changed_count),
        .distinct_values (distinct_values)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // a frame's final byte always leads to the result stage
    a_last_to_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (last_byte && last_reg) |=> (state_reg == fcs_pkg::S_EMIT))
        else $error("final pixel did not move to result stage");

    // hash restarts from the offset basis after a frame is closed
    a_hash_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.frame_clear |=> (hash_value == fcs_pkg::HASH_BASIS))
        else $error("hash not restarted after frame end");

    // changed count never passes its saturation limit
    a_changed_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        changed_count <= fcs_pkg::CHANGED_LIMIT)
        else $error("changed count beyond limit");

    // at most one byte value is added to the map per cycle
    a_distinct_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !ctl.frame_clear |=> (distinct_values == $past(distinct_values)
                           || distinct_values == $past(distinct_values) + 9'd1))
        else $error("distinct count jumped");

endmodule
